// ----- hw/rtl/hsta_pkg.sv -----
package hsta_pkg;

  localparam int unsigned ChW      = 8;
  localparam int unsigned NumCh    = 3;
  localparam int unsigned PixW     = 24;
  localparam int unsigned PctW     = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned HvW      = 15;
  localparam int unsigned DivNW    = 15;
  localparam int unsigned DivDW    = 9;
  localparam int unsigned SvW      = 12;
  localparam int unsigned Q100W    = 4;
  localparam int unsigned ProdW    = ChW + SvW;
  localparam int unsigned HlProdW  = ChW + HvW;
  localparam int unsigned TblDepth = 256;

  localparam logic [PctW-1:0] PctMax        = 7'd100;
  localparam logic [ChW-1:0]  ChMax         = 8'd255;
  localparam logic [15:0]     Recip100      = 16'd41944;
  localparam int unsigned     Recip100Shift = 22;
  localparam logic [15:0]     HlSatBase     = 16'd25600;
  localparam logic [DivDW-1:0] ShadowBase   = 9'd265;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HL_PCT = 2'd0,
    CFG_SH_PCT = 2'd1,
    CFG_FORMAT = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    FMT_RGB888 = 1'b0,
    FMT_RGB565 = 1'b1
  } pix_fmt_e;

  typedef enum logic [3:0] {
    BS_LEVEL,
    BS_HDIV_START,
    BS_HDIV_WAIT,
    BS_SDIV_START,
    BS_SDIV_WAIT,
    BS_MUL,
    BS_QUO,
    BS_WRITE,
    BS_READY
  } build_state_e;

  typedef struct packed {
    logic             ready;
    pix_fmt_e         fmt;
    logic             hl_act;
    logic [ChW-1:0]   level_h;
    logic [HvW-1:0]   hv;
  } tone_cfg_t;

  typedef struct packed {
    logic           we;
    logic [ChW-1:0] addr;
    logic [ChW-1:0] data;
  } tbl_wr_t;

  // Exact for x below 43690; every 15-bit caller value stays below 32768.
  function automatic logic [ChW-1:0] div100(input logic [14:0] x);
    logic [30:0] m;
    m = 31'(x) * 31'(Recip100);
    return m[Recip100Shift+ChW-1:Recip100Shift];
  endfunction

  function automatic logic [14:0] mul100(input logic [ChW-1:0] v);
    return 15'(v) * 15'd100;
  endfunction

endpackage

// ----- hw/rtl/hsta_ram.sv -----
module hsta_ram #(
  parameter int unsigned Width    = 8,
  parameter int unsigned Depth    = 256,
  parameter int unsigned NumReads = 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i [NumReads],
  output logic [Width-1:0]         rdata_o [NumReads]
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  for (genvar i = 0; i < NumReads; i++) begin : g_rd
    always_ff @(posedge clk_i) begin
      if (re_i) begin
        rdata_o[i] <= mem_q[raddr_i[i]];
      end
    end
  end

endmodule

// ----- hw/rtl/hsta_div.sv -----
module hsta_div
  import hsta_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] dividend_i,
  input  logic [DivDW-1:0] divisor_i,
  output logic             done_o,
  output logic [DivNW-1:0] quo_o,
  output logic [DivDW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(DivNW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivNW-1:0] quo_q, quo_d;
  logic [DivDW-1:0] rem_q, rem_d;
  logic [DivDW-1:0] dvs_q, dvs_d;
  logic [DivDW:0]   trial;
  logic             ge;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[DivNW-1]};
    ge     = trial >= {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DivDW'(trial - {1'b0, dvs_q}) : trial[DivDW-1:0];
      quo_d = {quo_q[DivNW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivNW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- hw/rtl/hsta_build.sv -----
module hsta_build
  import hsta_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [PctW-1:0]    cfg_data_i,
  output tone_cfg_t          tone_o,
  output tbl_wr_t            tbl_wr_o
);

  build_state_e state_q, state_d;

  logic [PctW-1:0]  hpct_q, spct_q;
  pix_fmt_e         fmt_q;
  logic             restart;

  logic [ChW-1:0]   lvl_h_q, lvl_h_d, lvl_s_q, lvl_s_d;
  logic [HvW-1:0]   hv_q, hv_d;
  logic [Q100W-1:0] q100_q, q100_d;
  logic [DivDW-1:0] r100_q, r100_d;
  logic [ChW-1:0]   v_q, v_d;
  logic [SvW-1:0]   sq_q, sq_d;
  logic [DivDW-1:0] sr_q, sr_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [ChW-1:0]   quo_q, quo_d;
  logic             zero_q, zero_d;

  logic [PctW-1:0]  hpct_sat, spct_sat;
  logic [DivDW-1:0] shadow_div;
  logic [DivDW:0]   sr_sum;

  logic             div_start;
  logic [DivNW-1:0] div_dividend;
  logic [DivDW-1:0] div_divisor;
  logic             div_done;
  logic [DivNW-1:0] div_quo;
  logic [DivDW-1:0] div_rem;

  hsta_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpct_q <= PctMax;
      spct_q <= '0;
      fmt_q  <= FMT_RGB888;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HL_PCT: hpct_q <= cfg_data_i;
        CFG_SH_PCT: spct_q <= cfg_data_i;
        CFG_FORMAT: fmt_q  <= pix_fmt_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_HL_PCT ||
                                cfg_idx_e'(cfg_idx_i) == CFG_SH_PCT);

  assign hpct_sat   = (hpct_q > PctMax) ? PctMax : hpct_q;
  assign spct_sat   = (spct_q > PctMax) ? PctMax : spct_q;
  assign shadow_div = ShadowBase - DivDW'(lvl_s_q);
  assign sr_sum     = {1'b0, sr_q} + {1'b0, r100_q};

  always_comb begin
    state_d      = state_q;
    lvl_h_d      = lvl_h_q;
    lvl_s_d      = lvl_s_q;
    hv_d         = hv_q;
    q100_d       = q100_q;
    r100_d       = r100_q;
    v_d          = v_q;
    sq_d         = sq_q;
    sr_d         = sr_q;
    prod_d       = prod_q;
    quo_d        = quo_q;
    zero_d       = zero_q;
    div_start    = 1'b0;
    div_dividend = 15'd100;
    div_divisor  = shadow_div;
    tbl_wr_o     = '0;
    tbl_wr_o.addr = v_q;
    case (state_q)
      BS_LEVEL: begin
        lvl_h_d = div100({hpct_sat, 8'b0} - 15'(hpct_sat));
        lvl_s_d = div100({spct_sat, 8'b0} - 15'(spct_sat));
        state_d = BS_HDIV_START;
      end
      BS_HDIV_START: begin
        if (lvl_h_q == '0 || lvl_h_q == ChMax) begin
          hv_d    = '0;
          state_d = BS_SDIV_START;
        end else begin
          div_start    = 1'b1;
          div_dividend = mul100(ChMax - lvl_h_q);
          div_divisor  = DivDW'(lvl_h_q);
          state_d      = BS_HDIV_WAIT;
        end
      end
      BS_HDIV_WAIT: begin
        if (div_done) begin
          hv_d    = div_quo + 1'b1;
          state_d = BS_SDIV_START;
        end
      end
      BS_SDIV_START: begin
        div_start = 1'b1;
        state_d   = BS_SDIV_WAIT;
      end
      BS_SDIV_WAIT: begin
        if (div_done) begin
          q100_d  = div_quo[Q100W-1:0];
          r100_d  = div_rem;
          v_d     = ChMax;
          sq_d    = '0;
          sr_d    = '0;
          state_d = BS_MUL;
        end
      end
      BS_MUL: begin
        prod_d  = ProdW'(v_q) * ProdW'(sq_q);
        state_d = BS_QUO;
      end
      BS_QUO: begin
        zero_d  = prod_q >= (ProdW'(mul100(v_q)) + ProdW'(100));
        quo_d   = div100(prod_q[14:0]);
        state_d = BS_WRITE;
      end
      BS_WRITE: begin
        tbl_wr_o.we = 1'b1;
        if (lvl_s_q == '0) begin
          tbl_wr_o.data = v_q;
        end else if (v_q <= lvl_s_q || zero_q) begin
          tbl_wr_o.data = '0;
        end else begin
          tbl_wr_o.data = v_q - quo_q;
        end
        if (v_q == '0) begin
          state_d = BS_READY;
        end else begin
          v_d     = v_q - 1'b1;
          state_d = BS_MUL;
          if (sr_sum >= {1'b0, shadow_div}) begin
            sr_d = DivDW'(sr_sum - {1'b0, shadow_div});
            sq_d = sq_q + SvW'(q100_q) + 1'b1;
          end else begin
            sr_d = sr_sum[DivDW-1:0];
            sq_d = sq_q + SvW'(q100_q);
          end
        end
      end
      BS_READY: ;
      default: state_d = BS_LEVEL;
    endcase
    if (restart) begin
      state_d = BS_LEVEL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_LEVEL;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_h_q <= lvl_h_d;
    lvl_s_q <= lvl_s_d;
    hv_q    <= hv_d;
    q100_q  <= q100_d;
    r100_q  <= r100_d;
    v_q     <= v_d;
    sq_q    <= sq_d;
    sr_q    <= sr_d;
    prod_q  <= prod_d;
    quo_q   <= quo_d;
    zero_q  <= zero_d;
  end

  assign tone_o.ready   = (state_q == BS_READY);
  assign tone_o.fmt     = fmt_q;
  assign tone_o.hl_act  = (lvl_h_q != ChMax);
  assign tone_o.level_h = lvl_h_q;
  assign tone_o.hv      = hv_q;

endmodule

// ----- hw/rtl/hsta_pipe.sv -----
module hsta_pipe
  import hsta_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tone_cfg_t       tone_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [PixW-1:0] pixel_word_i,
  input  logic            last_in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PixW-1:0] pixel_out_o,
  output logic            last_out_o,
  output logic            rd_en_o,
  output logic [ChW-1:0]  rd_addr_o [NumCh],
  input  logic [ChW-1:0]  rd_data_i [NumCh]
);

  logic           s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic           s1_en, s2_en, s3_en, out_en;

  logic [ChW-1:0] in_ch [NumCh];
  logic [ChW-1:0] s1_c_q [NumCh];
  logic           s1_last_q;

  logic [HlProdW-1:0] p_full [NumCh];
  logic [HlProdW-1:0] sat_lim [NumCh];
  logic [ChW-1:0]     s2_c_q [NumCh];
  logic [14:0]        s2_p_q [NumCh];
  logic               s2_sat_q [NumCh];
  logic               s2_byp_q [NumCh];
  logic               s2_last_q;

  logic           s3_byp_q [NumCh];
  logic           s3_last_q;

  logic [ChW-1:0]  res_ch [NumCh];
  logic [PixW-1:0] res_pix;
  logic [PixW-1:0] out_pix_q;
  logic            out_last_q;

  assign out_en     = !out_valid_q || out_ready_i;
  assign s3_en      = !s3_valid_q || out_en;
  assign s2_en      = !s2_valid_q || s3_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = tone_i.ready && s1_en;
  assign rd_en_o    = s3_en;

  always_comb begin
    case (tone_i.fmt)
      FMT_RGB565: begin
        in_ch[0] = {pixel_word_i[15:11], 3'b0};
        in_ch[1] = {pixel_word_i[10:5], 2'b0};
        in_ch[2] = {pixel_word_i[4:0], 3'b0};
      end
      default: begin
        in_ch[0] = pixel_word_i[23:16];
        in_ch[1] = pixel_word_i[15:8];
        in_ch[2] = pixel_word_i[7:0];
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      p_full[i]    = HlProdW'(s1_c_q[i]) * HlProdW'(tone_i.hv);
      sat_lim[i]   = HlProdW'(HlSatBase - 16'(mul100(s1_c_q[i])));
      rd_addr_o[i] = s2_c_q[i];
      if (tone_i.hl_act) begin
        rd_addr_o[i] = s2_sat_q[i] ? ChMax : s2_c_q[i] + div100(s2_p_q[i]);
      end
      res_ch[i] = s3_byp_q[i] ? ChMax : rd_data_i[i];
    end
  end

  always_comb begin
    case (tone_i.fmt)
      FMT_RGB565: res_pix = {8'b0, res_ch[0][7:3], res_ch[1][7:2], res_ch[2][7:3]};
      default:    res_pix = {res_ch[0], res_ch[1], res_ch[2]};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i && in_ready_o;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_en) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_en) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_c_q    <= in_ch;
      s1_last_q <= last_in_i;
    end
    if (s2_en) begin
      for (int i = 0; i < NumCh; i++) begin
        s2_c_q[i]   <= s1_c_q[i];
        s2_p_q[i]   <= p_full[i][14:0];
        s2_sat_q[i] <= p_full[i] >= sat_lim[i];
        s2_byp_q[i] <= tone_i.hl_act && (s1_c_q[i] >= tone_i.level_h);
      end
      s2_last_q <= s1_last_q;
    end
    if (s3_en) begin
      s3_byp_q  <= s2_byp_q;
      s3_last_q <= s2_last_q;
    end
    if (out_en) begin
      out_pix_q  <= res_pix;
      out_last_q <= s3_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pix_q;
  assign last_out_o  = out_last_q;

endmodule

// ----- hw/rtl/highlight_shadow_tone_adjust_unit.sv -----
// Highlight and shadow tone adjustment for RGB888 or RGB565 pixels, one pixel per
// transaction. Throughput is one pixel per cycle unless the output stalls; pixels
// pass registers s1, s2, s3 and the output register. The highlight gain is computed
// per channel in the pipeline and the shadow curve is read from a 256-entry table
// in two single-write RAMs (three read ports in total). After reset and after every
// write to either percent register the table is rebuilt by a sequencer with a
// serial divider, which skips the highlight division when highlight is off or at
// zero; no pixel is accepted during the rebuild. Pixel format writes take effect at
// once. Write configuration only when no transaction is in flight.
module highlight_shadow_tone_adjust_unit
  import hsta_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [PctW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PixW-1:0]    pixel_word_i,
  input  logic               last_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PixW-1:0]    pixel_out_o,
  output logic               last_out_o
);

  tone_cfg_t      tone;
  tbl_wr_t        tbl_wr;
  logic           rd_en;
  logic [ChW-1:0] rd_addr [NumCh];
  logic [ChW-1:0] rd_data [NumCh];
  logic [ChW-1:0] addr_rg [2];
  logic [ChW-1:0] data_rg [2];
  logic [ChW-1:0] addr_b [1];
  logic [ChW-1:0] data_b [1];

  hsta_build u_build (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .tone_o     (tone),
    .tbl_wr_o   (tbl_wr)
  );

  assign addr_rg[0] = rd_addr[0];
  assign addr_rg[1] = rd_addr[1];
  assign addr_b[0]  = rd_addr[2];
  assign rd_data[0] = data_rg[0];
  assign rd_data[1] = data_rg[1];
  assign rd_data[2] = data_b[0];

  hsta_ram #(
    .Width    (8),
    .Depth    (256),
    .NumReads (2)
  ) u_tbl_rg (
    .clk_i   (clk_i),
    .we_i    (tbl_wr.we),
    .waddr_i (tbl_wr.addr),
    .wdata_i (tbl_wr.data),
    .re_i    (rd_en),
    .raddr_i (addr_rg),
    .rdata_o (data_rg)
  );

  hsta_ram #(
    .Width    (8),
    .Depth    (256),
    .NumReads (1)
  ) u_tbl_b (
    .clk_i   (clk_i),
    .we_i    (tbl_wr.we),
    .waddr_i (tbl_wr.addr),
    .wdata_i (tbl_wr.data),
    .re_i    (rd_en),
    .raddr_i (addr_b),
    .rdata_o (data_b)
  );

  hsta_pipe u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tone_i       (tone),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_word_i (pixel_word_i),
    .last_in_i    (last_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_out_o  (pixel_out_o),
    .last_out_o   (last_out_o),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data)
  );

  a_no_accept_during_fill : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    tbl_wr.we |-> !in_ready_o
  ) else $error("pixel accepted while shadow table is being written");

  a_fill_ends_at_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(tone.ready) |-> $past(tbl_wr.we) && ($past(tbl_wr.addr) == '0)
  ) else $error("table marked ready before the last entry was written");

endmodule

// ----- test/highlight_shadow_tone_adjust_unit_tb.sv -----
module highlight_shadow_tone_adjust_unit_tb;
  import hsta_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongStall  = 300;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  typedef struct packed {
    logic [PixW-1:0] word;
    logic            last;
  } pixel_txn_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [PctW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [PixW-1:0]    pixel_word_i = '0;
  logic               last_in_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [PixW-1:0]    pixel_out_o;
  logic               last_out_o;

  pixel_txn_t  pending_pixels[$];
  pixel_txn_t  expected_pixels[$];
  logic [PctW-1:0] hl_pct_m = PctMax;
  logic [PctW-1:0] sh_pct_m = '0;
  pix_fmt_e    fmt_m = FMT_RGB888;
  int unsigned tx_mode = 0;
  int unsigned rx_mode = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned pixels_sent = 0;
  int unsigned pixels_seen = 0;
  int unsigned settings_run = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  highlight_shadow_tone_adjust_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_word_i (pixel_word_i),
    .last_in_i    (last_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_out_o  (pixel_out_o),
    .last_out_o   (last_out_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic int unsigned pct_level(logic [PctW-1:0] pct);
    int unsigned p;
    p = (pct > PctMax) ? 100 : pct;
    return p * 255 / 100;
  endfunction

  function automatic logic [ChW-1:0] tone_channel(int unsigned c, int unsigned h,
                                                  int unsigned s);
    int unsigned hv, v, sv, d;
    if (h < 255) begin
      if (c >= h) return ChMax;
      hv = (255 - h) * 100 / h + 1;
      v  = c + c * hv / 100;
      c  = (v > 255) ? 255 : v;
    end
    if (s > 0) begin
      if (c <= s) begin
        c = 0;
      end else begin
        sv = (255 - c) * 100 / (265 - s);
        d  = c * sv / 100;
        c  = (d > c) ? 0 : c - d;
      end
    end
    return c[ChW-1:0];
  endfunction

  function automatic pixel_txn_t adjust_pixel(logic [PixW-1:0] word, logic last);
    pixel_txn_t res;
    int unsigned h, s;
    logic [ChW-1:0] r, g, b;
    h = pct_level(hl_pct_m);
    s = pct_level(sh_pct_m);
    if (fmt_m == FMT_RGB888) begin
      r = word[23:16];
      g = word[15:8];
      b = word[7:0];
    end else begin
      r = {word[15:11], 3'b000};
      g = {word[10:5], 2'b00};
      b = {word[4:0], 3'b000};
    end
    r = tone_channel(r, h, s);
    g = tone_channel(g, h, s);
    b = tone_channel(b, h, s);
    if (fmt_m == FMT_RGB888) res.word = {r, g, b};
    else res.word = {8'h00, r[7:3], g[7:2], b[7:3]};
    res.last = last;
    return res;
  endfunction

  function automatic int unsigned pick_gap(int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [PctW-1:0] pick_pct();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PctMax;
      2: return 7'h7F;
      3: return 7'($urandom_range(101, 127));
      4: return 7'd1;
      default: return 7'($urandom_range(0, 100));
    endcase
  endfunction

  function automatic logic [ChW-1:0] near_level();
    int unsigned base;
    base = ($urandom_range(0, 1) != 0) ? pct_level(hl_pct_m) : pct_level(sh_pct_m);
    return 8'(base + $urandom_range(0, 2) - 1);
  endfunction

  task automatic queue_pixel(input logic [PixW-1:0] word, input logic last);
    pending_pixels.push_back('{word: word, last: last});
  endtask

  task automatic queue_random(input int unsigned count);
    logic [PixW-1:0] word;
    for (int unsigned i = 0; i < count; i++) begin
      word = 24'($urandom);
      if (fmt_m == FMT_RGB888 && $urandom_range(0, 3) == 0) begin
        word = {near_level(), near_level(), near_level()};
      end
      queue_pixel(word, 1'($urandom_range(0, 7) == 0));
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PctW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_HL_PCT: hl_pct_m = data;
      CFG_SH_PCT: sh_pct_m = data;
      CFG_FORMAT: fmt_m = pix_fmt_e'(data[0]);
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || expected_pixels.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : driver
    pixel_txn_t txn;
    logic       nxt_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      nxt_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        expected_pixels.push_back(adjust_pixel(pixel_word_i, last_in_i));
        pixels_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_pixels.size() != 0) begin
          txn = pending_pixels.pop_front();
          pixel_word_i <= txn.word;
          last_in_i    <= txn.last;
          nxt_valid = 1'b1;
          send_gap  = pick_gap(tx_mode);
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  always @(posedge clk_i) begin : monitor
    pixel_txn_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        pixels_seen++;
        if (expected_pixels.size() == 0) begin
          $error("unexpected transaction: pixel_out %h last_out %b", pixel_out_o,
                 last_out_o);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_out_o !== want.word) begin
            $error("pixel_out: expected %h, actual %h", want.word, pixel_out_o);
            mismatches++;
          end
          if (last_out_o !== want.last) begin
            $error("last_out: expected %b, actual %b", want.last, last_out_o);
            mismatches++;
          end
        end
        // hold off long enough for the pipeline to fill and stall the input
        if (pixels_seen == 250 || pixels_seen == 650) stall_left = LongStall;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap(rx_mode);
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_pixel(24'h000000, 1'b0);
    queue_pixel(24'hFFFFFF, 1'b1);
    queue_pixel(24'hA5C35A, 1'b0);
    wait_drained();

    write_reg(CFG_HL_PCT, 7'd60);
    write_reg(CFG_SH_PCT, 7'd30);
    write_reg(CFG_FORMAT, {6'h00, FMT_RGB888});
    end_writes();
    queue_pixel({8'd152, 8'd153, 8'd154}, 1'b0);
    queue_pixel({8'd75, 8'd76, 8'd77}, 1'b0);
    queue_pixel({8'd0, 8'd1, 8'd255}, 1'b0);
    queue_pixel(24'h808080, 1'b1);
    wait_drained();

    write_reg(CFG_HL_PCT, 7'd0);
    write_reg(CFG_SH_PCT, 7'h7F);
    write_reg(CFG_FORMAT, 7'h7F);
    end_writes();
    queue_pixel(24'h000000, 1'b0);
    queue_pixel(24'hFFFFFF, 1'b0);
    queue_pixel(24'h5A0000, 1'b1);
    queue_pixel(24'h00F81F, 1'b0);
    wait_drained();

    write_reg(CfgIdxSpare, 7'h55);
    write_reg(CFG_HL_PCT, 7'h7F);
    write_reg(CFG_SH_PCT, PctMax);
    end_writes();
    queue_pixel(24'hFF07E0, 1'b1);
    queue_pixel(24'h000001, 1'b0);
    queue_pixel(24'hA5FFFF, 1'b0);
    wait_drained();

    write_reg(CFG_HL_PCT, 7'd1);
    write_reg(CFG_SH_PCT, 7'd99);
    write_reg(CFG_FORMAT, {6'h3F, FMT_RGB888});
    end_writes();
    queue_pixel(24'h010203, 1'b0);
    queue_pixel(24'hFCFDFE, 1'b0);
    queue_pixel(24'hFFFFFF, 1'b1);
    wait_drained();

    for (int unsigned phase = 0; phase < 8; phase++) begin
      write_reg(CFG_HL_PCT, pick_pct());
      write_reg(CFG_SH_PCT, pick_pct());
      if ($urandom_range(0, 3) == 0) write_reg(CfgIdxSpare, 7'($urandom));
      write_reg(CFG_FORMAT, {6'($urandom), pix_fmt_e'($urandom_range(0, 1))});
      end_writes();
      tx_mode = (phase == 0) ? 0 : $urandom_range(0, 2);
      rx_mode = (phase == 0) ? 0 : $urandom_range(0, 2);
      if (phase == 4) begin
        // pause the sender until the block has drained, then resume
        queue_random(55);
        wait_drained();
        queue_random(55);
      end else begin
        queue_random(110);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("Covered %0d pixels in %0d register settings, RGB888 and RGB565,",
             pixels_sent, settings_run);
    $display("with random gaps, stalls and long output back-pressure.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
